// File: rtl/agsc_pkg.sv
// Shared types, constants and functions for the additive generator stream cipher.
package agsc_pkg;

    localparam int          PTR_W     = 6;
    localparam int          CNT_W     = 16;
    localparam int          WORD_W    = 32;
    localparam int          BYTE_W    = 8;

    localparam logic [WORD_W-1:0] LCG_MUL   = 32'd60554741;
    localparam logic [WORD_W-1:0] LCG_ADD   = 32'd937642419;
    localparam logic [WORD_W-1:0] LCG_START = 32'd6457513;

    localparam logic [PTR_W-1:0] LAG_TOP   = 6'd55;
    localparam logic [PTR_W-1:0] LAG_SHORT = 6'd24;

    // Counter values for the seeding phases; FILL_LAST is the last fill address, counted up from zero.
    localparam logic [CNT_W-1:0] WARM_LOAD = 16'd1000;   // 1000 advances plus one prefetch
    localparam logic [CNT_W-1:0] FILL_LAST = 16'd62;
    localparam logic [CNT_W-1:0] MIX_LOAD  = 16'd44443;
    localparam logic [CNT_W-1:0] KEY_LOAD  = 16'd33333;  // 33333 advances plus one prefetch
    localparam logic [CNT_W-1:0] KMIX_LOAD = 16'd999;
    localparam logic [CNT_W-1:0] TAIL_LOAD = 16'd5499;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WARM,
        S_FILL,
        S_MIX,
        S_KEY,
        S_KMIX,
        S_TAIL,
        S_FIRST,
        S_RUN
    } t_state;

    function automatic logic [WORD_W-1:0] lcg_next(input logic [WORD_W-1:0] w);
        lcg_next = LCG_ADD + LCG_MUL * w;
    endfunction

    // Lagged sum folded to its absolute value; 0x80000000 maps to itself.
    function automatic logic [WORD_W-1:0] gen_word(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b,
                                                   input logic [WORD_W-1:0] extra);
        logic [WORD_W-1:0] sum;
        sum = a + b + extra;
        gen_word = sum[WORD_W-1] ? (~sum + 32'd1) : sum;
    endfunction

endpackage

// File: rtl/agsc_ram.sv
// Generic RAM: one write port, two registered read ports.
module agsc_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: rtl/additive_generator_stream_cipher.sv
// Byte stream cipher: data XOR keystream from a 55/24 lagged additive generator.
// One table read-modify-write per byte; each byte is registered in the input stage,
// then XORed into the output register. One byte per cycle once seeded, unless stalled.
// The first byte starts keyed seeding: LCG and generator steps, one per cycle
// through the table RAM, before that byte's own step.
// Reset (sync, active low) clears control, pointers and key; table RAM is not cleared.
module additive_generator_stream_cipher
    import agsc_pkg::*;
#(
    parameter int TABLE_WORDS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_wdata,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [BYTE_W-1:0] i_s_axis_tdata,   // [7:0] data_in
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [BYTE_W-1:0] o_m_axis_tdata    // [7:0] data_out
);

    localparam int AW = $clog2(TABLE_WORDS);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PTR_W-1:0]  r_long, n_long;
    logic [PTR_W-1:0]  r_short, n_short;
    logic [WORD_W-1:0] r_lcg, n_lcg;
    logic [WORD_W-1:0] r_stream_key;
    logic              r_s1_valid, n_s1_valid;
    logic [BYTE_W-1:0] r_s1_data;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_data;

    logic              accept;
    logic              s1_go;
    logic              gen_step;
    logic              item_step;
    logic [PTR_W-1:0]  dec_long, dec_short;
    logic [WORD_W-1:0] extra;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] rd_long, rd_short;

    assign s1_go  = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        o_s_axis_tready = 1'b0;
        if (r_state == S_IDLE) begin
            o_s_axis_tready = 1'b1;
        end else if (r_state == S_RUN) begin
            o_s_axis_tready = !r_s1_valid || s1_go;
        end
    end

    // Pointer decrement with wrap back to the top lag.
    always_comb begin
        dec_long  = r_long - 6'd1;
        dec_short = r_short - 6'd1;
        if (dec_short == '0) begin
            dec_short = LAG_TOP;
        end else if (dec_long == '0) begin
            dec_long = LAG_TOP;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_lcg     = r_lcg;
        gen_step  = 1'b0;
        item_step = 1'b0;
        extra     = '0;
        ram_we    = 1'b0;
        ram_waddr = AW'(r_long);
        ram_wdata = r_lcg;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_WARM;
                    n_cnt   = WARM_LOAD;
                    n_lcg   = LCG_START;
                end
            end
            S_WARM: begin
                n_lcg = lcg_next(r_lcg);
                if (r_cnt == '0) begin
                    n_state = S_FILL;
                end else begin
                    n_cnt = r_cnt - 16'd1;
                end
            end
            S_FILL: begin
                n_lcg     = lcg_next(r_lcg);
                ram_we    = (r_cnt < CNT_W'(TABLE_WORDS));
                ram_waddr = AW'(r_cnt);
                if (r_cnt == FILL_LAST) begin
                    n_state = S_MIX;
                    n_cnt   = MIX_LOAD;
                end else begin
                    n_cnt = r_cnt + 16'd1;
                end
            end
            S_MIX: begin
                gen_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_KEY;
                    n_cnt   = KEY_LOAD;
                    n_lcg   = r_stream_key;
                end else begin
                    n_cnt = r_cnt - 16'd1;
                end
            end
            S_KEY: begin
                n_lcg = lcg_next(r_lcg);
                if (r_cnt == '0) begin
                    n_state = S_KMIX;
                    n_cnt   = KMIX_LOAD;
                end else begin
                    n_cnt = r_cnt - 16'd1;
                end
            end
            S_KMIX: begin
                // r_lcg already holds the advanced word for this step
                gen_step = 1'b1;
                extra    = r_lcg;
                n_lcg    = lcg_next(r_lcg);
                if (r_cnt == '0) begin
                    n_state = S_TAIL;
                    n_cnt   = TAIL_LOAD;
                end else begin
                    n_cnt = r_cnt - 16'd1;
                end
            end
            S_TAIL: begin
                gen_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIRST;
                end else begin
                    n_cnt = r_cnt - 16'd1;
                end
            end
            S_FIRST: begin
                gen_step  = 1'b1;
                item_step = 1'b1;
                n_state   = S_RUN;
            end
            S_RUN: begin
                gen_step  = accept;
                item_step = accept;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (gen_step) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_long);
            ram_wdata = gen_word(rd_long, rd_short, extra);
        end
    end

    // Reads address the next pointers so the words are ready for the next step.
    always_comb begin
        n_long  = r_long;
        n_short = r_short;
        if (r_state == S_TAIL && r_cnt == '0) begin
            n_long  = LAG_TOP;
            n_short = LAG_SHORT;
        end else if (gen_step) begin
            n_long  = dec_long;
            n_short = dec_short;
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (item_step) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_go) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    agsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_WORDS)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (AW'(n_long)),
        .o_rdata_a (rd_long),
        .i_raddr_b (AW'(n_short)),
        .o_rdata_b (rd_short)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_long       <= LAG_TOP;
            r_short      <= LAG_SHORT;
            r_stream_key <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_long      <= n_long;
            r_short     <= n_short;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_stream_key <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lcg <= n_lcg;
        if (accept) begin
            r_s1_data <= i_s_axis_tdata;
        end
        if (s1_go) begin
            // keystream byte is bits 10..3 of the word at the new long pointer
            r_out_data <= r_s1_data ^ rd_long[10:3];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_long != '0) && (r_long <= LAG_TOP) && (r_short != '0) && (r_short <= LAG_TOP))
        else $error("lag pointer out of range");

    a_ptr_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long != r_short)
        else $error("long and short pointers collide");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (gen_step) |-> (AW'(r_long) != AW'(n_long)) && (AW'(r_long) != AW'(n_short)))
        else $error("table write hits an address read in the same cycle");

    a_busy_seeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_RUN) |-> !o_s_axis_tready)
        else $error("input ready during seeding");

    a_s1_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s1_valid) |-> $past(item_step))
        else $error("stage valid without a generator step");
`endif

endmodule

// File: test/tb_additive_generator_stream_cipher.sv
// Testbench for the additive generator stream cipher: keyed seeding and keystream XOR checks.
module tb_additive_generator_stream_cipher;
    import agsc_pkg::*;

    localparam int TABLE_WORDS = 64;
    localparam int HOLD_LEN    = 400;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [WORD_W-1:0] cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic [BYTE_W-1:0] s_data = '0;
    logic              m_ready = 1'b0;
    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [BYTE_W-1:0] o_m_axis_tdata;

    // Receiver control: the tests flip hold_trig, the receiver counts the hold-off itself.
    logic              rx_stalls = 1'b0;
    logic              hold_trig = 1'b0;
    logic              hold_seen = 1'b0;
    int                hold_left = 0;
    int                stall_left = 0;

    // Keystream predictor state.
    bit [WORD_W-1:0]   ks_table [TABLE_WORDS];
    bit [PTR_W-1:0]    ks_long = LAG_TOP;
    bit [PTR_W-1:0]    ks_short = LAG_SHORT;
    bit                ks_seeded = 1'b0;
    bit [WORD_W-1:0]   ks_lcg = '0;
    bit [WORD_W-1:0]   key_shadow = '0;

    bit [BYTE_W-1:0]   pending_bytes [$];
    bit [BYTE_W-1:0]   want_byte;
    int                err_count = 0;

    additive_generator_stream_cipher #(
        .TABLE_WORDS(TABLE_WORDS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void lcg_advance();
        ks_lcg = LCG_ADD + LCG_MUL * ks_lcg;
    endfunction

    function automatic void lag_advance(input bit [WORD_W-1:0] extra);
        bit [WORD_W-1:0] v;
        v = ks_table[ks_long] + ks_table[ks_short] + extra;
        if (v[WORD_W-1])
            v = 32'd0 - v;
        ks_table[ks_long] = v;
        ks_long  = ks_long - 1'b1;
        ks_short = ks_short - 1'b1;
        if (ks_short == 0)
            ks_short = LAG_TOP;
        else if (ks_long == 0)
            ks_long = LAG_TOP;
    endfunction

    function automatic void seed_table();
        ks_lcg = LCG_START;
        repeat (1000) lcg_advance();
        for (int i = 0; i < 63; i++) begin
            lcg_advance();
            if (i < TABLE_WORDS)
                ks_table[i] = ks_lcg;
        end
        repeat (44444) lag_advance('0);
        ks_lcg = key_shadow;
        repeat (33333) lcg_advance();
        repeat (1000) begin
            lcg_advance();
            lag_advance(ks_lcg);
        end
        repeat (5500) lag_advance('0);
        ks_long   = LAG_TOP;
        ks_short  = LAG_SHORT;
        ks_seeded = 1'b1;
    endfunction

    function automatic bit [BYTE_W-1:0] cipher_byte(input bit [BYTE_W-1:0] b);
        if (!ks_seeded)
            seed_table();
        lag_advance('0);
        return b ^ ks_table[ks_long][10:3];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Predict on every input transfer, check on every output transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                if (pending_bytes.size() == 0) begin
                    report_mismatch($sformatf("output 0x%02h with nothing expected",
                                              o_m_axis_tdata));
                end else begin
                    want_byte = pending_bytes.pop_front();
                    if (o_m_axis_tdata !== want_byte)
                        report_mismatch($sformatf("data_out 0x%02h, expected 0x%02h",
                                                  o_m_axis_tdata, want_byte));
                end
            end
            if (s_valid && o_s_axis_tready)
                pending_bytes.push_back(cipher_byte(s_data));
        end
    end

    always @(negedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!rx_stalls) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        s_valid <= 1'b1;
        s_data  <= b;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [WORD_W-1:0] v);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        key_shadow = v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Key written before the first byte; only the last write reaches the seeding.
    task automatic test_key_setup();
        logic [WORD_W-1:0] key;
        case ($urandom_range(0, 2))
            0:       key = 32'h0000_0000;
            1:       key = 32'hFFFF_FFFF;
            default: key = $urandom;
        endcase
        cfg_write(32'hFFFF_FFFF);
        cfg_write(32'h0000_0000);
        cfg_write(key);
    endtask

    // First byte triggers seeding; then byte extremes and walking patterns.
    task automatic test_directed();
        rx_stalls <= 1'b0;
        send_byte(8'h00);
        send_byte(8'hFF);
        for (int i = 0; i < BYTE_W; i++)
            send_byte(8'h01 << i);
        for (int i = 0; i < BYTE_W; i++)
            send_byte(~(8'h01 << i));
        send_byte(8'h55);
        send_byte(8'hAA);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int burst;
        sent = 0;
        rx_stalls <= 1'b1;
        while (sent < n_items) begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                send_byte(BYTE_W'($urandom_range(0, 255)));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end
        wait_drain();
    endtask

    // Receiver holds off long enough that the input side must stall.
    task automatic test_backpressure();
        rx_stalls <= 1'b0;
        hold_trig <= ~hold_trig;
        for (int k = 0; k < 64; k++)
            send_byte(BYTE_W'($urandom_range(0, 255)));
        wait_drain();
    endtask

    // A key written after seeding must not disturb the running keystream.
    task automatic test_key_change();
        cfg_write(32'h0000_0000);
        cfg_write(32'hFFFF_FFFF);
        cfg_write($urandom);
        test_random_traffic(100);
    endtask

    task automatic test_no_idle(input int n_items);
        rx_stalls <= 1'b0;
        for (int k = 0; k < n_items; k++)
            send_byte(BYTE_W'($urandom_range(0, 255)));
        wait_drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_key_setup();
        test_directed();
        test_random_traffic(850);
        test_backpressure();
        test_key_change();
        test_no_idle(200);
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5000000;
        $display("TIMEOUT @%0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
